@@ rtl/core/drop_oldest_chunk_queue_assert.svh @@
// assertion helpers for the queue rtl
`ifndef DROP_OLDEST_CHUNK_QUEUE_ASSERT_SVH
`define DROP_OLDEST_CHUNK_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define DOCQ_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DOCQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/docq_pkg.sv @@
package docq_pkg;

	// operation codes
	localparam logic [1:0] MODE_PUSH  = 2'd0;
	localparam logic [1:0] MODE_POP   = 2'd1;
	localparam logic [1:0] MODE_CLOSE = 2'd2;

	// result codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_DROPPED = 2'd1;
	localparam logic [1:0] STATUS_CLOSED  = 2'd2;
	localparam logic [1:0] STATUS_EMPTY   = 2'd3;

	// register indexes
	localparam logic [3:0] REG_CHUNK_LIMIT = 4'd0;
	localparam logic [3:0] REG_BYTE_LIMIT  = 4'd1;

	localparam logic [6:0]  CHUNK_LIMIT_RST = 7'd64;
	localparam logic [31:0] BYTE_LIMIT_RST  = 32'd8388608;
	localparam logic [6:0]  MIN_CHUNKS      = 7'd2;
	localparam logic [31:0] MIN_BYTES       = 32'd1024 * 32'd1024;

	typedef struct packed {
		logic [1:0]  mode;
		logic [23:0] chunk_len;
		logic [31:0] chunk_tag;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [23:0] out_len;
		logic [31:0] out_tag;
		logic [6:0]  dropped_count;
		logic [6:0]  queued_chunks;
		logic [31:0] queued_bytes;
	} rsp_t;

	typedef struct packed {
		logic [3:0]  index;
		logic [31:0] value;
	} cfg_t;

	typedef struct packed {
		logic [23:0] len;
		logic [31:0] tag;
	} entry_t;

endpackage

@@ rtl/core/docq_stream_if.sv @@
interface docq_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/drop_oldest_chunk_queue.sv @@
// drop-oldest chunk descriptor queue
// req (sink, docq_pkg::req_t): one item per operation - push a (length, tag)
//   descriptor, pop the oldest one, or close the queue
// rsp (source, docq_pkg::rsp_t): exactly one item per request item, in order,
//   carrying status, popped descriptor, drop count and the fill after the step
// cfg (sink, docq_pkg::cfg_t): register writes, always ready; index 0 is the
//   chunk limit, index 1 the byte budget; other indexes are ignored
// states passed from request accept until the response is loaded:
//   close, reserved, refused push, empty pop: ST_FIN only
//   pop: ST_POP, ST_FIN; push: ST_EVAL, ST_DROP+ST_EVAL per drop, ST_FIN
// every drop is a read of the head entry's length from the descriptor
//   memory and a write-back of the totals
// one request is worked on at a time; the next request is taken at the edge
//   after the previous response is loaded into the output register
// reset: queue empty, not closed, limits at 64 chunks and 8 MiB; the
//   descriptor memory is not cleared, nothing is read before it is written
// a stalled receiver holds the response; a finished request then waits in
//   its last state until the output register frees up
`include "drop_oldest_chunk_queue_assert.svh"

module drop_oldest_chunk_queue #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	docq_stream_if.sink   req,
	docq_stream_if.source rsp,
	docq_stream_if.sink   cfg
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	// width for comparing the count against the 7 bit limit register
	localparam int LW = (CW > 7) ? CW : 7;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EVAL = 5'b00010,
		ST_DROP = 5'b00100,
		ST_POP  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q;

	// queue bookkeeping
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [31:0]   bytes_q;
	logic          closed_q;

	// limit registers, raw as written
	logic [6:0]  chunk_limit_q;
	logic [31:0] byte_limit_q;

	// per-request working registers
	logic [23:0]   len_q;
	logic [31:0]   tag_q;
	logic [1:0]    status_q;
	logic [23:0]   olen_q;
	logic [31:0]   otag_q;
	logic [CW-1:0] dropped_q;

	// output register
	logic             out_valid_q;
	docq_pkg::rsp_t   out_q;

	// descriptor memory, one synchronous read port at the head
	docq_pkg::entry_t entry_mem [QUEUE_DEPTH];
	docq_pkg::entry_t rd_entry_q;

	logic          req_fire;
	logic          out_free;
	logic          mem_wr;
	logic [LW-1:0] eff_chunks;
	logic [LW-1:0] cl_clip;
	logic [31:0]   eff_bytes;
	logic [32:0]   bytes_sum;
	logic          need_drop;
	logic [PW-1:0] head_nxt;
	logic [PW-1:0] tail_nxt;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// effective limits: chunk limit clamped into [2, depth], bytes to at least 1 MiB
	always_comb begin
		cl_clip = (LW'(chunk_limit_q) > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH)
			: LW'(chunk_limit_q);
		eff_chunks = (cl_clip < LW'(docq_pkg::MIN_CHUNKS)) ? LW'(docq_pkg::MIN_CHUNKS)
			: cl_clip;
		eff_bytes = (byte_limit_q < docq_pkg::MIN_BYTES) ? docq_pkg::MIN_BYTES
			: byte_limit_q;
	end

	// drop the head while the new chunk does not fit and something is queued
	assign bytes_sum = {1'b0, bytes_q} + 33'(len_q);
	assign need_drop = (count_q != '0) &&
		((LW'(count_q) >= eff_chunks) || (bytes_sum > {1'b0, eff_bytes}));

	assign head_nxt = (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	// descriptor append happens once the drop loop is done
	assign mem_wr = (state_q == ST_EVAL) && !need_drop;

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			entry_mem[tail_q] <= '{len: len_q, tag: tag_q};
		end
		// head is always being read; writes land before the head entry is used
		rd_entry_q <= entry_mem[head_q];
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_limit_q <= docq_pkg::CHUNK_LIMIT_RST;
			byte_limit_q  <= docq_pkg::BYTE_LIMIT_RST;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.data.index == docq_pkg::REG_CHUNK_LIMIT) begin
				chunk_limit_q <= cfg.data.value[6:0];
			end else if (cfg.data.index == docq_pkg::REG_BYTE_LIMIT) begin
				byte_limit_q <= cfg.data.value;
			end
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			bytes_q     <= '0;
			closed_q    <= 1'b0;
			len_q       <= '0;
			tag_q       <= '0;
			status_q    <= docq_pkg::STATUS_OK;
			olen_q      <= '0;
			otag_q      <= '0;
			dropped_q   <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// a new response may replace one taken in the same cycle
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						len_q     <= req.data.chunk_len;
						tag_q     <= req.data.chunk_tag;
						olen_q    <= '0;
						otag_q    <= '0;
						dropped_q <= '0;
						status_q  <= docq_pkg::STATUS_OK;
						state_q   <= ST_FIN;
						if (req.data.mode == docq_pkg::MODE_PUSH) begin
							if (closed_q) begin
								status_q <= docq_pkg::STATUS_CLOSED;
							end else begin
								state_q <= ST_EVAL;
							end
						end else if (req.data.mode == docq_pkg::MODE_POP) begin
							if (count_q == '0) begin
								status_q <= docq_pkg::STATUS_EMPTY;
							end else begin
								state_q <= ST_POP;
							end
						end else if (req.data.mode == docq_pkg::MODE_CLOSE) begin
							closed_q <= 1'b1;
						end
					end
				end
				ST_EVAL: begin
					if (need_drop) begin
						state_q <= ST_DROP;
					end else begin
						tail_q   <= tail_nxt;
						count_q  <= count_q + 1'b1;
						bytes_q  <= bytes_q + 32'(len_q);
						status_q <= (dropped_q != '0) ? docq_pkg::STATUS_DROPPED
							: docq_pkg::STATUS_OK;
						state_q  <= ST_FIN;
					end
				end
				ST_DROP: begin
					// head length arrived from memory
					bytes_q   <= bytes_q - 32'(rd_entry_q.len);
					head_q    <= head_nxt;
					count_q   <= count_q - 1'b1;
					dropped_q <= dropped_q + 1'b1;
					state_q   <= ST_EVAL;
				end
				ST_POP: begin
					olen_q  <= rd_entry_q.len;
					otag_q  <= rd_entry_q.tag;
					bytes_q <= bytes_q - 32'(rd_entry_q.len);
					head_q  <= head_nxt;
					count_q <= count_q - 1'b1;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_q.status        <= status_q;
						out_q.out_len       <= olen_q;
						out_q.out_tag       <= otag_q;
						out_q.dropped_count <= 7'(dropped_q);
						out_q.queued_chunks <= 7'(count_q);
						out_q.queued_bytes  <= bytes_q;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`DOCQ_ASSERT_IMPLIES(a_count_bound, 1'b1, count_q <= CW'(QUEUE_DEPTH),
		"entry count above queue depth")
	`DOCQ_ASSERT_IMPLIES(a_drop_nonempty, state_q == ST_DROP, count_q != '0,
		"drop from an empty queue")
	`DOCQ_ASSERT_IMPLIES(a_pop_nonempty, state_q == ST_POP, count_q != '0,
		"pop from an empty queue")
	`DOCQ_ASSERT_IMPLIES(a_drop_status,
		state_q == ST_FIN && status_q == docq_pkg::STATUS_DROPPED, dropped_q != '0,
		"drop status without any dropped entry")
	`DOCQ_ASSERT_NEXT(a_closed_sticky, closed_q, closed_q, "closed flag cleared")

endmodule

@@ bench/drop_oldest_chunk_queue_tb.sv @@
`timescale 1ns / 100ps

module drop_oldest_chunk_queue_tb;

	localparam int DEPTH = 64;
	// slowest correct run stays far below this
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	// long drop chains keep the block busy; this settle time covers them
	localparam int SETTLE_CYCLES = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_REPORTS = 60;
	// an index the block must ignore
	localparam logic [3:0] REG_UNUSED = 4'd9;
	localparam logic [1:0] MODE_RESERVED = 2'd3;

	// who idles in the current phase
	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_BOTH,
		IDLE_SEND,
		IDLE_RECV
	} idle_style_t;

	logic clk;
	logic arst_n;

	docq_stream_if #(.T(docq_pkg::req_t)) req_if ();
	docq_stream_if #(.T(docq_pkg::rsp_t)) rsp_if ();
	docq_stream_if #(.T(docq_pkg::cfg_t)) cfg_if ();

	drop_oldest_chunk_queue #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	// shadow copy of the descriptor queue and its registers
	docq_pkg::entry_t held_entries[$];
	logic [31:0]      held_bytes = '0;
	bit               queue_closed = 1'b0;
	logic [6:0]       lim_chunks;
	logic [31:0]      lim_bytes;

	// items waiting for the driver, replies waiting for the block
	docq_pkg::req_t pending_ops[$];
	docq_pkg::rsp_t awaited_replies[$];

	idle_style_t idle_style;
	bit          hold_req;
	bit          hold_taken;

	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned n_items = 0, n_pushes = 0, n_refused = 0, n_dropped = 0;
	int unsigned n_pops = 0, n_empty = 0;
	int unsigned n_settings;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// effective limits, clamped as the block clamps them
	function automatic int unsigned chunk_cap();
		int unsigned cl;
		cl = (lim_chunks < docq_pkg::MIN_CHUNKS) ? 32'(docq_pkg::MIN_CHUNKS)
			: 32'(lim_chunks);
		if (cl > 32'(DEPTH))
			cl = 32'(DEPTH);
		return cl;
	endfunction

	function automatic logic [32:0] byte_cap();
		return (lim_bytes < docq_pkg::MIN_BYTES) ? {1'b0, docq_pkg::MIN_BYTES}
			: {1'b0, lim_bytes};
	endfunction

	// apply one accepted item to the shadow queue, return the reply it earns
	function automatic docq_pkg::rsp_t predict_reply(docq_pkg::req_t item);
		docq_pkg::rsp_t   o;
		docq_pkg::entry_t e;
		int unsigned      drops;
		int unsigned      cl;
		logic [32:0]      bl;
		o = '0;
		drops = 0;
		cl = chunk_cap();
		bl = byte_cap();
		n_items++;
		unique case (item.mode)
			docq_pkg::MODE_PUSH: begin
				n_pushes++;
				if (queue_closed) begin
					o.status = docq_pkg::STATUS_CLOSED;
					n_refused++;
				end else begin
					// make room: oldest entries go first, even past an oversized chunk
					while (held_entries.size() > 0 &&
					       (held_entries.size() >= cl ||
					        {1'b0, held_bytes} + {9'd0, item.chunk_len} > bl)) begin
						e = held_entries[0];
						held_entries.delete(0);
						held_bytes -= {8'd0, e.len};
						drops++;
					end
					e.len = item.chunk_len;
					e.tag = item.chunk_tag;
					held_entries = {held_entries, e};
					held_bytes += {8'd0, item.chunk_len};
					o.status = (drops != 0) ? docq_pkg::STATUS_DROPPED : docq_pkg::STATUS_OK;
					o.dropped_count = drops[6:0];
					n_dropped += drops;
				end
			end
			docq_pkg::MODE_POP: begin
				n_pops++;
				if (held_entries.size() == 0) begin
					// empty answers the same whether closed or not
					o.status = docq_pkg::STATUS_EMPTY;
					n_empty++;
				end else begin
					e = held_entries[0];
					held_entries.delete(0);
					held_bytes -= {8'd0, e.len};
					o.out_len = e.len;
					o.out_tag = e.tag;
				end
			end
			docq_pkg::MODE_CLOSE: queue_closed = 1'b1;
			default: ;	// reserved mode leaves everything alone
		endcase
		o.queued_chunks = 7'(held_entries.size());
		o.queued_bytes = held_bytes;
		return o;
	endfunction

	// per-item wait, zero on the side that does not idle in this phase
	function automatic int unsigned pick_gap(input bit sender);
		bit busy_side;
		busy_side = (idle_style == IDLE_BOTH) ||
		            (sender && idle_style == IDLE_SEND) ||
		            (!sender && idle_style == IDLE_RECV);
		if (!busy_side || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 13);
	endfunction

	// driver: offers items from pending_ops, predicts each one on accept
	int unsigned send_gap;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.data <= '0;
			send_gap <= 0;
		end else if (!(req_if.valid && !req_if.ready)) begin
			// nothing offered, or the offered item was just taken
			if (req_if.valid && req_if.ready)
				awaited_replies = {awaited_replies, predict_reply(req_if.data)};
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				req_if.valid <= 1'b0;
			end else if (pending_ops.size() != 0) begin
				req_if.valid <= 1'b1;
				req_if.data <= pending_ops[0];
				pending_ops.delete(0);
				send_gap <= pick_gap(1'b1);
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] exp_v,
	                           input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
		end
	endtask

	// long hold-off of the receiver, counted on its own
	int unsigned hold_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_taken <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor: takes replies, compares with the oldest awaited one, paces ready
	int unsigned    recv_stall;
	int unsigned    recv_draw;
	docq_pkg::rsp_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (awaited_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$error("reply with no item outstanding: 0x%0h", rsp_if.data);
				end else begin
					want = awaited_replies[0];
					awaited_replies.delete(0);
					check_field("status", 32'(want.status), 32'(rsp_if.data.status));
					check_field("out_len", 32'(want.out_len), 32'(rsp_if.data.out_len));
					check_field("out_tag", want.out_tag, rsp_if.data.out_tag);
					check_field("dropped_count", 32'(want.dropped_count),
					            32'(rsp_if.data.dropped_count));
					check_field("queued_chunks", 32'(want.queued_chunks),
					            32'(rsp_if.data.queued_chunks));
					check_field("queued_bytes", want.queued_bytes,
					            rsp_if.data.queued_bytes);
				end
			end
			// long hold-off: the block fills its output and stalls req
			if ((hold_req && !hold_taken) || hold_left > 1) begin
				rsp_if.ready <= 1'b0;
			end else if (hold_left == 1) begin
				rsp_if.ready <= 1'b1;
			end else if (rsp_if.valid && rsp_if.ready) begin
				recv_draw = pick_gap(1'b0);
				recv_stall <= recv_draw;
				rsp_if.ready <= (recv_draw == 0);
			end else if (recv_stall != 0) begin
				recv_stall <= recv_stall - 1;
				rsp_if.ready <= (recv_stall == 1);
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies still awaited",
			         cycle_count, awaited_replies.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic queue_op(input logic [1:0] mode, input logic [23:0] len,
	                        input logic [31:0] tag);
		docq_pkg::req_t item;
		item.mode = mode;
		item.chunk_len = len;
		item.chunk_tag = tag;
		pending_ops = {pending_ops, item};
	endtask

	// wait until the block is idle: everything sent and answered
	task automatic drain();
		while (pending_ops.size() != 0 || req_if.valid || awaited_replies.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write, only called while the block is idle
	task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= '{index: idx, value: val};
		do
			@(posedge clk);
		while (!cfg_if.ready);
		if (idx == docq_pkg::REG_CHUNK_LIMIT)
			lim_chunks = val[6:0];
		else if (idx == docq_pkg::REG_BYTE_LIMIT)
			lim_bytes = val;
		cfg_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	// length mix: zero, max, tiny chunks for the count limit, budget-sized ones
	function automatic logic [23:0] pick_len();
		int unsigned r;
		logic [32:0] span;
		r = $urandom_range(0, 99);
		span = byte_cap() >> 2;
		if (span > 33'hFF_FFFF)
			span = 33'hFF_FFFF;
		if (r < 5)
			return '0;
		if (r < 10)
			return 24'hFF_FFFF;
		if (r < 45)
			return 24'($urandom_range(0, 4095));
		if (r < 85)
			return 24'($urandom_range(0, 32'(span[23:0])));
		return 24'($urandom());
	endfunction

	// random items; close only where the phase allows it (it is sticky)
	task automatic random_ops(input int unsigned count, input bit allow_close);
		int unsigned r;
		logic [1:0]  mode;
		for (int unsigned i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (allow_close && r < 5)
				mode = docq_pkg::MODE_CLOSE;
			else if (r < 57)
				mode = docq_pkg::MODE_PUSH;
			else if (r < 94)
				mode = docq_pkg::MODE_POP;
			else
				mode = MODE_RESERVED;
			queue_op(mode, pick_len(), $urandom());
		end
	endtask

	// one limit setting, then a batch of random items under it
	task automatic run_setting(input logic [31:0] chunk_val, input logic [31:0] byte_val,
	                           input idle_style_t style, input int unsigned count,
	                           input bit with_hold);
		write_reg(docq_pkg::REG_CHUNK_LIMIT, chunk_val);
		write_reg(docq_pkg::REG_BYTE_LIMIT, byte_val);
		n_settings++;
		idle_style = style;
		random_ops(count, 1'b0);
		if (with_hold)
			hold_req = 1'b1;
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		hold_req = 1'b0;
		idle_style = IDLE_BOTH;
		lim_chunks = docq_pkg::CHUNK_LIMIT_RST;
		lim_bytes = docq_pkg::BYTE_LIMIT_RST;
		n_settings = 1;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset limits (64 chunks, 8 MiB)
		queue_op(docq_pkg::MODE_POP, 24'h0, 32'h0);               // pop of an empty queue
		queue_op(MODE_RESERVED, 24'hFF_FFFF, 32'hFFFF_FFFF);      // reserved mode is a no-op
		queue_op(docq_pkg::MODE_PUSH, 24'h0, 32'h0);
		queue_op(docq_pkg::MODE_PUSH, 24'hFF_FFFF, 32'hFFFF_FFFF); // oversized, stored anyway
		queue_op(docq_pkg::MODE_PUSH, 24'h5A_5A5A, 32'hA5A5_A5A5); // pushes the oversized one out
		queue_op(docq_pkg::MODE_PUSH, 24'd100, 32'h1111_0001);
		queue_op(docq_pkg::MODE_PUSH, 24'd200, 32'h1111_0002);
		queue_op(docq_pkg::MODE_PUSH, 24'd300, 32'h1111_0003);
		queue_op(docq_pkg::MODE_POP, 24'hFF_FFFF, 32'hFFFF_FFFF);
		queue_op(docq_pkg::MODE_PUSH, 24'h80_0000, 32'h2222_0000); // exactly the budget
		queue_op(docq_pkg::MODE_POP, 24'h0, 32'h0);
		queue_op(docq_pkg::MODE_POP, 24'h0, 32'h0);
		drain();

		// chunk limit below the floor clamps to two
		write_reg(docq_pkg::REG_CHUNK_LIMIT, 32'd1);
		n_settings++;
		queue_op(docq_pkg::MODE_PUSH, 24'd1, 32'h3333_0001);
		queue_op(docq_pkg::MODE_PUSH, 24'd2, 32'h3333_0002);
		queue_op(docq_pkg::MODE_PUSH, 24'd3, 32'h3333_0003);
		drain();

		// fill under a roomy limit, then lower it with entries held
		write_reg(docq_pkg::REG_CHUNK_LIMIT, 32'd64);
		for (int i = 0; i < 5; i++)
			queue_op(docq_pkg::MODE_PUSH, 24'(10 + i), 32'h4444_0000 + 32'(i));
		drain();
		write_reg(docq_pkg::REG_CHUNK_LIMIT, 32'hFFFF_FF83);  // upper bits ignored, 3 in use
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);                 // unknown index, no effect
		n_settings++;
		queue_op(docq_pkg::MODE_PUSH, 24'd7, 32'h5555_0000);  // drops down to fit
		drain();

		// byte budget below the floor clamps to one mebibyte
		write_reg(docq_pkg::REG_BYTE_LIMIT, 32'd0);
		n_settings++;
		queue_op(docq_pkg::MODE_PUSH, 24'h10_0000, 32'h6666_0001);
		queue_op(docq_pkg::MODE_PUSH, 24'h0, 32'h6666_0002);
		queue_op(docq_pkg::MODE_PUSH, 24'd1, 32'h6666_0003);
		queue_op(docq_pkg::MODE_POP, 24'h0, 32'h0);
		drain();

		// random phases across the limit range, extremes included
		run_setting(32'd64, 32'd8388608, IDLE_BOTH, 180, 1'b0);
		run_setting(32'd127, 32'hFFFF_FFFF, IDLE_NONE, 180, 1'b1);
		run_setting(32'd0, 32'd0, IDLE_SEND, 180, 1'b0);
		run_setting(32'd2, 32'd1048576, IDLE_RECV, 180, 1'b0);
		run_setting(32'd7, 32'd1048575, IDLE_BOTH, 180, 1'b0);
		run_setting(32'd33, 32'd3000000, IDLE_BOTH, 180, 1'b0);
		run_setting(32'hFFFF_FF40, 32'd50000000, IDLE_NONE, 180, 1'b0);
		run_setting({25'($urandom() >> 7), 7'($urandom_range(0, 127))}, $urandom(),
		            IDLE_BOTH, 170, 1'b0);
		run_setting({25'($urandom() >> 7), 7'($urandom_range(0, 127))},
		            32'($urandom_range(32'h10_0000, 32'h100_0000)), IDLE_BOTH, 170, 1'b0);

		// closing comes last since the flag never clears
		write_reg(docq_pkg::REG_CHUNK_LIMIT, 32'(docq_pkg::CHUNK_LIMIT_RST));
		write_reg(docq_pkg::REG_BYTE_LIMIT, docq_pkg::BYTE_LIMIT_RST);
		n_settings++;
		idle_style = IDLE_BOTH;
		queue_op(docq_pkg::MODE_PUSH, 24'd500, 32'h7777_0001);
		queue_op(docq_pkg::MODE_CLOSE, 24'hFF_FFFF, 32'hFFFF_FFFF);
		queue_op(docq_pkg::MODE_CLOSE, 24'h0, 32'h0);             // second close is still ok
		queue_op(docq_pkg::MODE_PUSH, 24'd600, 32'h7777_0002);    // refused
		queue_op(MODE_RESERVED, 24'h0, 32'h0);
		for (int i = 0; i < 70; i++)                              // drain a closed queue
			queue_op(docq_pkg::MODE_POP, 24'h0, 32'h0);
		random_ops(40, 1'b1);
		drain();

		$display("covered %0d items under %0d limit settings: %0d pushes (%0d refused)",
		         n_items, n_settings, n_pushes, n_refused);
		$display("  %0d entries dropped on push, %0d pops (%0d on an empty queue)",
		         n_dropped, n_pops, n_empty);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
